[hw/rtl/fcpa_pkg.sv]
// Shared constants, codes and types of the fixed chunk pool allocator.
package fcpa_pkg;

  // Pool geometry
  localparam int POOL_CHUNKS = 256;
  localparam int IDX_W       = $clog2(POOL_CHUNKS);
  localparam int LINK_W      = $clog2(POOL_CHUNKS + 1);

  // Field widths
  localparam int CPB_W    = 9;
  localparam int CB_W     = 13;
  localparam int CIDX_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OFS_W    = 20;
  localparam int CMP_W    = ((LINK_W > CPB_W) ? LINK_W : CPB_W) + 1;
  localparam int PROD_W   = CMP_W + CB_W;

  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_CHUNKS);
  localparam logic [CMP_W-1:0]  END_CMP  = CMP_W'(POOL_CHUNKS);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_PER_BLOCK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES      = 1'd1;
  localparam logic [CPB_W-1:0] CPB_RESET = 9'd8;
  localparam logic [CB_W-1:0]  CB_RESET  = 13'd16;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOC     = 2'd0,
    STATUS_RELEASE   = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CARVE,
    S_READ,
    S_POP,
    S_FINISH
  } state_t;

endpackage

[hw/rtl/fcpa_if.sv]
// Request, response and configuration channel interfaces of the allocator.
interface fcpa_req_if import fcpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CIDX_W-1:0] chunk_index;

  modport source (output valid, output command, output chunk_index, input ready);
  modport sink   (input valid, input command, input chunk_index, output ready);
endinterface

interface fcpa_rsp_if import fcpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CIDX_W-1:0]   granted_index;
  logic [OFS_W-1:0]    byte_offset;

  modport source (output valid, output status, output granted_index, output byte_offset,
                  input ready);
  modport sink   (input valid, input status, input granted_index, input byte_offset,
                  output ready);
endinterface

interface fcpa_cfg_if import fcpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/fcpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fcpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/fixed_chunk_pool_allocator_unit.sv]
// Fixed chunk pool allocator: LIFO free list in a link RAM, carved block by block.
//
// One request is worked at a time; req.ready is high only while the sequencer is idle.
// A release is accepted, then loaded into the response register. An allocate
// that finds the free list non-empty steps through accept, link RAM read, pop and offset
// multiply, response load. When the list is empty, the allocate first writes one link per
// cycle through the single RAM write port, chunks_per_block links in all for the block
// (a block size of 0 counts as 1); if the block no longer fits in the pool, it answers
// exhausted. The response is held in its own register, so the next request is taken while
// a result still waits on rsp. No clearing pass after reset.
module fixed_chunk_pool_allocator_unit import fcpa_pkg::*; (
  input logic       clk,
  input logic       rst,
  fcpa_req_if.sink  req,
  fcpa_rsp_if.source rsp,
  fcpa_cfg_if.sink  cfg
);

  state_t state, state_next;

  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] carved;
  logic [LINK_W-1:0] carve_ptr;
  logic [CPB_W-1:0]  chunks_per_block;
  logic [CB_W-1:0]   chunk_bytes;

  logic [STATUS_W-1:0] res_status;
  logic [CIDX_W-1:0]   res_index;
  logic [OFS_W-1:0]    res_offset;

  logic              rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [CIDX_W-1:0] rsp_index;
  logic [OFS_W-1:0]  rsp_offset;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [LINK_W-1:0] mem_rdata;

  logic              req_fire;
  logic              slot_free;
  logic [CMP_W-1:0]  rel_ext;
  logic              rel_ok;
  logic [CMP_W-1:0]  blk_n;
  logic [CMP_W-1:0]  room;
  logic              fits;
  logic              head_empty;
  logic [LINK_W-1:0] carve_inc;
  logic              carve_last;
  logic [CMP_W-1:0]  carved_sum;
  logic [PROD_W-1:0] product;
  logic [CMP_W-1:0]  head_ext;

  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign req_fire   = req.valid && req.ready;
  assign slot_free  = !rsp_valid || rsp.ready;

  assign rel_ext    = CMP_W'(req.chunk_index);
  assign rel_ok     = rel_ext < END_CMP;
  assign blk_n      = (chunks_per_block == '0) ? CMP_W'(1) : CMP_W'(chunks_per_block);
  assign room       = END_CMP - CMP_W'(carved);
  assign fits       = blk_n <= room;
  assign carved_sum = CMP_W'(carved) + blk_n;
  assign head_empty = (head == END_MARK);
  assign carve_inc  = carve_ptr + LINK_W'(1);
  // carved already holds the end of the block being linked
  assign carve_last = (carve_inc == carved);
  assign head_ext   = CMP_W'(head);
  assign product    = PROD_W'(head_ext) * PROD_W'(chunk_bytes);

  fcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_CHUNKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.command == CMD_RELEASE) begin
            state_next = S_FINISH;
          end else if (!head_empty) begin
            state_next = S_READ;
          end else if (fits) begin
            state_next = S_CARVE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_CARVE: begin
        if (carve_last) begin
          state_next = S_READ;
        end
      end
      S_READ:   state_next = S_POP;
      S_POP:    state_next = S_FINISH;
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Link RAM control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rel_ext[IDX_W-1:0];
    mem_wdata = head;
    mem_raddr = head_ext[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        mem_we = req_fire && (req.command == CMD_RELEASE) && rel_ok;
      end
      S_CARVE: begin
        mem_we    = 1'b1;
        mem_waddr = carve_ptr[IDX_W-1:0];
        mem_wdata = carve_last ? END_MARK : carve_inc;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      head             <= END_MARK;
      carved           <= '0;
      chunks_per_block <= CPB_RESET;
      chunk_bytes      <= CB_RESET;
      rsp_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_CHUNKS_PER_BLOCK: chunks_per_block <= cfg.data[CPB_W-1:0];
          REG_CHUNK_BYTES:      chunk_bytes      <= cfg.data[CB_W-1:0];
          default:              chunks_per_block <= chunks_per_block;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.command == CMD_RELEASE) begin
              if (rel_ok) begin
                head <= rel_ext[LINK_W-1:0];
              end
            end else if (head_empty && fits) begin
              // Claim the block now; the links follow one per cycle
              head      <= carved;
              carve_ptr <= carved;
              carved    <= carved_sum[LINK_W-1:0];
            end
          end
        end
        S_CARVE: begin
          carve_ptr <= carve_inc;
        end
        S_POP: begin
          head <= (mem_rdata < END_MARK) ? mem_rdata : END_MARK;
        end
        default: begin
          head <= head;
        end
      endcase

      if (state == S_FINISH && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_fire) begin
      res_index  <= '0;
      res_offset <= '0;
      res_status <= (req.command == CMD_RELEASE) ? STATUS_RELEASE : STATUS_EXHAUSTED;
    end
    if (state == S_POP) begin
      res_status <= STATUS_ALLOC;
      res_index  <= head_ext[CIDX_W-1:0];
      res_offset <= product[OFS_W-1:0];
    end
    if (state == S_FINISH && slot_free) begin
      rsp_status <= res_status;
      rsp_index  <= res_index;
      rsp_offset <= res_offset;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.granted_index = rsp_index;
  assign rsp.byte_offset   = rsp_offset;

endmodule
